// File: src/ffa_pkg.sv
// Shared constants, types and status codes for the first-fit allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package ffa_pkg;

    // Pool geometry, in header units.
    localparam int UNIT_BYTES  = 16;
    localparam int PAGE_UNITS  = 256;
    localparam int POOL_PAGES  = 16;
    localparam int STORE_DEPTH = 1 + POOL_PAGES * PAGE_UNITS;
    localparam int PAGE_BYTES  = PAGE_UNITS * UNIT_BYTES;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);

    // Field widths of the request and response words, and of the page counter.
    localparam int ADDR_W   = 13;
    localparam int SIZE_W   = 16;
    localparam int PAGE_W   = $clog2(POOL_PAGES + 1);

    // Bounds on list walks; a walk past them means a corrupted list.
    localparam int WALK_CAP   = STORE_DEPTH + 2;
    localparam int SEARCH_CAP = WALK_CAP * (POOL_PAGES + 2);
    localparam int WSTEP_W    = $clog2(WALK_CAP + 2);
    localparam int SSTEP_W    = $clog2(SEARCH_CAP + 2);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Write commands for the header memory: size and next arrays separately.
    typedef struct packed {
        logic              size_en;
        logic [ADDR_W-1:0] size_addr;
        logic [ADDR_W-1:0] size_data;
        logic              next_en;
        logic [ADDR_W-1:0] next_addr;
        logic [ADDR_W-1:0] next_data;
    } hdr_wr_t;

endpackage

`default_nettype wire

// File: src/ffa_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on ffa_pkg for field widths.
`default_nettype none

interface ffa_req_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, req_type, size_bytes, block_addr, input ready);
    modport sink   (input valid, req_type, size_bytes, block_addr, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_addr;

    modport source (output valid, status, result_addr, input ready);
    modport sink   (input valid, status, result_addr, output ready);
endinterface

`default_nettype wire

// File: src/ffa_hdr_mem.sv
// Header memory: block size and next link per unit, registered read.
// Depends on ffa_pkg; entry 0 (sentinel) lives in a register.
`default_nettype none

module ffa_hdr_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ffa_pkg::ADDR_W-1:0] rd_addr,
    input  wire ffa_pkg::hdr_wr_t          wr,
    output logic [ffa_pkg::ADDR_W-1:0]     rd_size,
    output logic [ffa_pkg::ADDR_W-1:0]     rd_next
);
    import ffa_pkg::*;

    logic [ADDR_W-1:0] size_mem [STORE_DEPTH];
    logic [ADDR_W-1:0] next_mem [STORE_DEPTH];
    logic [ADDR_W-1:0] sent_next_reg;
    logic [ADDR_W-1:0] size_q;
    logic [ADDR_W-1:0] next_q;
    logic              rd_zero_reg;
    logic              rd_oob_reg;

    // Size array write port; out-of-store writes are dropped.
    always_ff @(posedge clk)
    begin
        if (wr.size_en && wr.size_addr != '0 && 32'(wr.size_addr) < STORE_DEPTH)
        begin
            size_mem[wr.size_addr] <= wr.size_data;
        end
    end

    // Next array write port.
    always_ff @(posedge clk)
    begin
        if (wr.next_en && wr.next_addr != '0 && 32'(wr.next_addr) < STORE_DEPTH)
        begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
    end

    // Sentinel link register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_next_reg <= '0;
        end
        else if (wr.next_en && wr.next_addr == '0)
        begin
            sent_next_reg <= wr.next_data;
        end
    end

    // Registered read of both arrays.
    always_ff @(posedge clk)
    begin
        if (32'(rd_addr) < STORE_DEPTH)
        begin
            size_q <= size_mem[rd_addr];
            next_q <= next_mem[rd_addr];
        end
        rd_zero_reg <= (rd_addr == '0);
        rd_oob_reg  <= (32'(rd_addr) >= STORE_DEPTH);
    end

    // The sentinel reads as size one; out-of-store reads give zero.
    always_comb
    begin
        if (rd_zero_reg)
        begin
            rd_size = ADDR_W'(1);
            rd_next = sent_next_reg;
        end
        else if (rd_oob_reg)
        begin
            rd_size = '0;
            rd_next = '0;
        end
        else
        begin
            rd_size = size_q;
            rd_next = next_q;
        end
    end

endmodule

`default_nettype wire

// File: src/first_fit_free_list_allocator_core.sv
// First-fit free-list allocator with coalescing: sequencer around the header memory.
// Depends on ffa_pkg, ffa_if (channel interfaces) and ffa_hdr_mem.
//
//   channel | dir | word contents
//   --------+-----+----------------------------------
//   req     | in  | req_type, size_bytes, block_addr
//   rsp     | out | status, result_addr
//
// One request at a time. Each visited list node costs one header memory read;
// an allocate searches the list (with an extra write state for a split) plus a
// release walk per pool page brought in, and a free is a single release walk.
// Reset leaves an empty list holding only the sentinel; no clearing pass.
// A waiting response holds the block in its final state until it is taken.
`default_nettype none

module first_fit_free_list_allocator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    import ffa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_AHEAD  = 11'b00000000010,
        S_ACHK   = 11'b00000000100,
        S_ASPLIT = 11'b00000001000,
        S_RSTART = 11'b00000010000,
        S_RCHK   = 11'b00000100000,
        S_RB     = 11'b00001000000,
        S_RN     = 11'b00010000000,
        S_RL     = 11'b00100000000,
        S_ARES   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  rover_reg, rover_next;
    logic [PAGE_W-1:0]  pages_reg, pages_next;
    logic [ADDR_W-1:0]  prev_reg, prev_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [ADDR_W-1:0]  units_reg, units_next;
    logic [SSTEP_W-1:0] steps_reg, steps_next;
    logic [ADDR_W-1:0]  b_reg, b_next;
    logic [ADDR_W-1:0]  wcur_reg, wcur_next;
    logic [WSTEP_W-1:0] wsteps_reg, wsteps_next;
    logic [ADDR_W-1:0]  nx_reg, nx_next;
    logic [ADDR_W-1:0]  cursz_reg, cursz_next;
    logic [ADDR_W-1:0]  bsz_reg, bsz_next;
    logic [ADDR_W-1:0]  after_reg, after_next;
    logic [ADDR_W-1:0]  nbsz_reg, nbsz_next;
    logic               ret_alloc_reg, ret_alloc_next;
    status_t            pst_reg, pst_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic               out_valid_reg, out_valid_next;
    status_t            ost_reg, ost_next;
    logic [ADDR_W-1:0]  oaddr_reg, oaddr_next;

    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  rd_size;
    logic [ADDR_W-1:0]  rd_next;
    hdr_wr_t            wr;

    logic [SIZE_W:0]    size_round;
    logic [SSTEP_W-1:0] steps_inc;
    logic [WSTEP_W-1:0] wsteps_inc;
    logic [ADDR_W-1:0]  tail;
    logic [ADDR_W-1:0]  blk_hdr;
    logic [ADDR_W:0]    b_end;
    logic [ADDR_W:0]    cur_end;
    logic               walk_stop;

    ffa_hdr_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_size (rd_size),
        .rd_next (rd_next)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = ost_reg;
    assign rsp.result_addr = oaddr_reg;

    // Shared arithmetic for the sequencer.
    assign size_round = ({1'b0, req.size_bytes} + (SIZE_W + 1)'(UNIT_BYTES - 1)) >> UNIT_SHIFT;
    assign steps_inc  = steps_reg + SSTEP_W'(1);
    assign wsteps_inc = wsteps_reg + WSTEP_W'(1);
    assign tail       = cur_reg + units_reg;
    assign blk_hdr    = req.block_addr - ADDR_W'(1);
    assign b_end      = {1'b0, b_reg} + {1'b0, bsz_reg};
    assign cur_end    = {1'b0, wcur_reg} + {1'b0, cursz_reg};
    assign walk_stop  = (wcur_reg < b_reg && b_reg < rd_next) ||
                        (rd_next <= wcur_reg && (b_reg > wcur_reg || b_reg < rd_next));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rover_next     = rover_reg;
        pages_next     = pages_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        units_next     = units_reg;
        steps_next     = steps_reg;
        b_next         = b_reg;
        wcur_next      = wcur_reg;
        wsteps_next    = wsteps_reg;
        nx_next        = nx_reg;
        cursz_next     = cursz_reg;
        bsz_next       = bsz_reg;
        after_next     = after_reg;
        nbsz_next      = nbsz_reg;
        ret_alloc_next = ret_alloc_reg;
        pst_next       = pst_reg;
        paddr_next     = paddr_reg;
        out_valid_next = out_valid_reg;
        ost_next       = ost_reg;
        oaddr_next     = oaddr_reg;
        rd_addr        = rover_reg;
        wr             = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pst_next   = ST_OK;
                    paddr_next = '0;
                    if (req.req_type == REQ_FREE)
                    begin
                        b_next         = blk_hdr;
                        ret_alloc_next = 1'b0;
                        if (req.block_addr == '0 || blk_hdr == '0 ||
                            32'(blk_hdr) >= STORE_DEPTH)
                        begin
                            pst_next   = ST_BAD_FREE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RSTART;
                        end
                    end
                    else if (req.size_bytes == '0 || 32'(req.size_bytes) >= PAGE_BYTES)
                    begin
                        pst_next   = ST_BAD_SIZE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        units_next = ADDR_W'(size_round) + ADDR_W'(1);
                        prev_next  = rover_reg;
                        steps_next = '0;
                        rd_addr    = rover_reg;
                        state_next = S_AHEAD;
                    end
                end
            end

            S_AHEAD:
            begin
                cur_next   = rd_next;
                rd_addr    = rd_next;
                state_next = S_ACHK;
            end

            S_ACHK:
            begin
                if (rd_size >= units_reg)
                begin
                    wr.next_en   = 1'b1;
                    wr.next_addr = prev_reg;
                    wr.next_data = rd_next;
                    if (rd_size == units_reg)
                    begin
                        rover_next = prev_reg;
                        paddr_next = cur_reg + ADDR_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Split: the tail header stays free.
                        wr.next_addr = tail;
                        wr.size_en   = 1'b1;
                        wr.size_addr = tail;
                        wr.size_data = rd_size - units_reg;
                        state_next   = S_ASPLIT;
                    end
                end
                else if (cur_reg == rover_reg)
                begin
                    if (32'(pages_reg) >= POOL_PAGES)
                    begin
                        pst_next   = ST_NO_MEM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Bring in the next pool page as one free block.
                        b_next         = ADDR_W'(1 + 32'(pages_reg) * PAGE_UNITS);
                        pages_next     = pages_reg + PAGE_W'(1);
                        wr.size_en     = 1'b1;
                        wr.size_addr   = ADDR_W'(1 + 32'(pages_reg) * PAGE_UNITS);
                        wr.size_data   = ADDR_W'(PAGE_UNITS);
                        wr.next_en     = 1'b1;
                        wr.next_addr   = ADDR_W'(1 + 32'(pages_reg) * PAGE_UNITS);
                        wr.next_data   = '0;
                        ret_alloc_next = 1'b1;
                        state_next     = S_RSTART;
                    end
                end
                else
                begin
                    steps_next = steps_inc;
                    if (32'(steps_inc) > SEARCH_CAP)
                    begin
                        pst_next   = ST_NO_MEM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = rd_next;
                        rd_addr   = rd_next;
                    end
                end
            end

            S_ASPLIT:
            begin
                wr.next_en   = 1'b1;
                wr.next_addr = prev_reg;
                wr.next_data = tail;
                wr.size_en   = 1'b1;
                wr.size_addr = cur_reg;
                wr.size_data = units_reg;
                rover_next   = prev_reg;
                paddr_next   = cur_reg + ADDR_W'(1);
                state_next   = S_DONE;
            end

            S_RSTART:
            begin
                rd_addr     = rover_reg;
                wcur_next   = rover_reg;
                wsteps_next = '0;
                state_next  = S_RCHK;
            end

            // Walk to the node after which b belongs.
            S_RCHK:
            begin
                if (walk_stop)
                begin
                    nx_next    = rd_next;
                    cursz_next = rd_size;
                    rd_addr    = b_reg;
                    state_next = S_RB;
                end
                else
                begin
                    wsteps_next = wsteps_inc;
                    if (32'(wsteps_inc) > WALK_CAP)
                    begin
                        pst_next   = ret_alloc_reg ? ST_NO_MEM : ST_BAD_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wcur_next = rd_next;
                        rd_addr   = rd_next;
                    end
                end
            end

            S_RB:
            begin
                bsz_next   = rd_size;
                rd_addr    = nx_reg;
                state_next = S_RN;
            end

            // Merge with the right neighbor.
            S_RN:
            begin
                wr.next_en   = 1'b1;
                wr.next_addr = b_reg;
                if (nx_reg != '0 && b_end == {1'b0, nx_reg})
                begin
                    nbsz_next    = bsz_reg + rd_size;
                    after_next   = rd_next;
                    wr.size_en   = 1'b1;
                    wr.size_addr = b_reg;
                    wr.size_data = bsz_reg + rd_size;
                    wr.next_data = rd_next;
                end
                else
                begin
                    nbsz_next    = bsz_reg;
                    after_next   = nx_reg;
                    wr.next_data = nx_reg;
                end
                state_next = S_RL;
            end

            // Merge with the left neighbor, or link b behind it.
            S_RL:
            begin
                wr.next_en   = 1'b1;
                wr.next_addr = wcur_reg;
                if (wcur_reg != '0 && cur_end == {1'b0, b_reg})
                begin
                    wr.size_en   = 1'b1;
                    wr.size_addr = wcur_reg;
                    wr.size_data = cursz_reg + nbsz_reg;
                    wr.next_data = after_reg;
                end
                else
                begin
                    wr.next_data = b_reg;
                end
                rover_next = wcur_reg;
                state_next = ret_alloc_reg ? S_ARES : S_DONE;
            end

            // Resume the search from the new rover.
            S_ARES:
            begin
                steps_next = steps_inc;
                if (32'(steps_inc) > SEARCH_CAP)
                begin
                    pst_next   = ST_NO_MEM;
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next  = rover_reg;
                    rd_addr    = rover_reg;
                    state_next = S_AHEAD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = pst_reg;
                    oaddr_next     = (pst_reg == ST_OK) ? paddr_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rover_reg     <= '0;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
            ret_alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            pages_reg     <= pages_next;
            out_valid_reg <= out_valid_next;
            ret_alloc_reg <= ret_alloc_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        units_reg  <= units_next;
        steps_reg  <= steps_next;
        b_reg      <= b_next;
        wcur_reg   <= wcur_next;
        wsteps_reg <= wsteps_next;
        nx_reg     <= nx_next;
        cursz_reg  <= cursz_next;
        bsz_reg    <= bsz_next;
        after_reg  <= after_next;
        nbsz_reg   <= nbsz_next;
        pst_reg    <= pst_next;
        paddr_reg  <= paddr_next;
        ost_reg    <= ost_next;
        oaddr_reg  <= oaddr_next;
    end

endmodule

`default_nettype wire
